// ===== design/spf_pkg.sv =====
`timescale 1ns / 1ps

package spf_pkg;

    // block geometry
    localparam int BLOCK_SAMPLES = 512;
    localparam int MAX_PEAKS     = 16;
    localparam int SAMPLE_BITS   = 16;

    localparam int ADDR_W   = $clog2(BLOCK_SAMPLES);
    localparam int CNT_W    = $clog2(BLOCK_SAMPLES + 1);
    localparam int PIDX_W   = $clog2(MAX_PEAKS);
    localparam int PCNT_W   = $clog2(MAX_PEAKS + 2);
    localparam int SCALED_W = SAMPLE_BITS + 6;
    localparam int EXT_W    = ADDR_W + SAMPLE_BITS;

    // configuration registers
    localparam int GAP_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SAMPLE_BITS:0]   work_t;
    typedef logic signed [SCALED_W-1:0]    scaled_t;
    typedef logic [ADDR_W-1:0]             pos_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic [PIDX_W-1:0]             pidx_t;
    typedef logic [PCNT_W-1:0]             pcnt_t;
    typedef logic [GAP_W-1:0]              gap_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]         cfg_data_t;

    localparam cfg_idx_t REG_MIN_PEAK_GAP = 1'b0;
    localparam cfg_idx_t REG_FIND_MINIMA  = 1'b1;

    localparam gap_t    GAP_RESET      = gap_t'(60);
    localparam logic    FIND_MIN_RESET = 1'b1;
    localparam sample_t SAMPLE_MIN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam sample_t SAMPLE_MAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam pcnt_t   PEAK_LIMIT     = pcnt_t'(MAX_PEAKS);
    localparam pcnt_t   PEAK_SAT       = pcnt_t'(MAX_PEAKS + 1);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan;
        logic scan_end;
        logic decide;
        logic walk;
        logic fin;
        logic emit_rd;
        logic emit_ld;
        logic emit_next;
        logic clear;
    } spf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic walk_done;
        logic small_block;
        logic emit_last;
    } spf_status_t;

    // sample in the analysis domain, negated when valleys are wanted
    function automatic work_t to_work(sample_t raw, logic neg);
        work_t w;
        w = work_t'(raw);
        return neg ? -w : w;
    endfunction

    function automatic scaled_t times5(work_t v);
        scaled_t x;
        x = scaled_t'(v);
        return (x <<< 2) + x;
    endfunction

    function automatic pcnt_t sat_inc(pcnt_t c);
        return (c == PEAK_SAT) ? c : c + pcnt_t'(1);
    endfunction

endpackage

// ===== design/spf_sample_if.sv =====
`timescale 1ns / 1ps

interface spf_sample_if;
    logic                   valid;
    logic                   ready;
    spf_pkg::sample_t       sample;
    logic                   block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink (input valid, input sample, input block_end, output ready);
endinterface

// ===== design/spf_peak_if.sv =====
`timescale 1ns / 1ps

interface spf_peak_if;
    logic                   valid;
    logic                   ready;
    spf_pkg::pos_t          peak_position;
    spf_pkg::sample_t       peak_level;
    logic                   none_found;
    logic                   last_peak;

    modport source (output valid, output peak_position, output peak_level,
                    output none_found, output last_peak, input ready);
    modport sink (input valid, input peak_position, input peak_level,
                  input none_found, input last_peak, output ready);
endinterface

// ===== design/spf_ram.sv =====
`timescale 1ns / 1ps

module spf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== design/spf_ctrl.sv =====
`timescale 1ns / 1ps

module spf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_block_end,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  spf_pkg::spf_status_t status,
    output spf_pkg::spf_cmd_t    cmd
);
    import spf_pkg::*;

    typedef enum logic [3:0] {
        LOAD, SCAN, SCAN_END, DECIDE, WALK, FINAL, EMIT_RD, EMIT_LD, EMIT_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire, out_fire;

    assign in_ready  = (state_reg == LOAD);
    assign out_valid = out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    // command decode
    always_comb
    begin
        cmd           = '0;
        cmd.load      = in_fire;
        cmd.scan_init = in_fire && in_block_end;
        cmd.scan      = (state_reg == SCAN);
        cmd.scan_end  = (state_reg == SCAN_END);
        cmd.decide    = (state_reg == DECIDE);
        cmd.walk      = (state_reg == WALK);
        cmd.fin       = (state_reg == FINAL);
        cmd.emit_rd   = (state_reg == EMIT_RD);
        cmd.emit_ld   = (state_reg == EMIT_LD);
        cmd.emit_next = out_fire && !status.emit_last;
        cmd.clear     = out_fire && status.emit_last;
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            LOAD:
            begin
                if (in_fire && in_block_end)
                begin
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = SCAN_END;
                end
            end
            SCAN_END:  state_next = DECIDE;
            DECIDE:    state_next = status.small_block ? EMIT_RD : WALK;
            WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = FINAL;
                end
            end
            FINAL:     state_next = EMIT_RD;
            EMIT_RD:   state_next = EMIT_LD;
            EMIT_LD:
            begin
                state_next     = EMIT_WAIT;
                out_valid_next = 1'b1;
            end
            EMIT_WAIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    state_next     = status.emit_last ? LOAD : EMIT_RD;
                end
            end
            default:
            begin
                state_next     = LOAD;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // samples are never taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid_reg))
        else $error("input open while result pending");

    // end of scan stream only seen while scanning
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        status.scan_done |-> state_reg == SCAN)
        else $error("scan end outside scan");

    // last result of a block reopens the input
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && status.emit_last) |=> in_ready)
        else $error("input not reopened after last result");

endmodule

// ===== design/spf_dp.sv =====
`timescale 1ns / 1ps

module spf_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spf_pkg::spf_cmd_t      cmd,
    output spf_pkg::spf_status_t   status,
    input  logic                   cfg_we,
    input  spf_pkg::cfg_idx_t      cfg_index,
    input  spf_pkg::cfg_data_t     cfg_data,
    input  spf_pkg::sample_t       in_sample,
    output spf_pkg::pos_t          out_position,
    output spf_pkg::sample_t       out_level,
    output logic                   out_none,
    output logic                   out_last
);
    import spf_pkg::*;

    // configuration
    gap_t    min_gap_reg;
    logic    find_min_reg;

    // block load
    count_t  count_reg;
    sample_t max_reg, min_reg;
    scaled_t range_s;

    // memories
    logic             smp_we;
    pos_t             smp_raddr;
    sample_t          smp_rdata;
    logic             ext_we;
    pos_t             ext_waddr, ext_raddr;
    logic [EXT_W-1:0] ext_rdata;

    // extrema scan
    count_t  rd_i_reg, j1_reg, len_reg;
    logic    v1_reg, dprev_reg, scan_issue;
    sample_t prev_raw_reg;
    work_t   w_cur, w_prev, cand_w, min_mag_reg;
    logic    d_cur;
    pos_t    cand_pos;
    sample_t cand_raw;
    pos_t    e_pos_reg [3];
    sample_t e_raw_reg [3];

    // decision on the first candidates
    work_t   ew0, ew1, ew2, dec_f0_val, dec_f1_val;
    pos_t    dec_f0_pos;
    logic    gt0, lt0, gt1, lt1, same, dec_s, sm_xi, sm_hit;

    // hysteresis walk
    logic    b_reg, s_reg, v2_reg, found_reg, walk_issue;
    count_t  l_reg, wk_reg, k2_reg;
    pos_t    f0_pos_reg, el_pos, last_pos_reg, temp_pos_reg, last_p_reg;
    work_t   f0_val_reg, el_v, temp_mag_reg, left_min_reg, last_v_reg, tm_eff;
    pcnt_t   cnt_reg;
    logic    par, is_end, gap_ok, peak_ok, valley_hit;
    logic signed [ADDR_W+1:0] gap_diff;

    // closing step
    work_t   tm_fin;
    logic    fin_hit_last, fin_hit_tmp, fin_add;
    pos_t    fin_pos;
    pcnt_t   cnt_f, np_f;

    // peak list and emit
    pos_t    plist_reg [MAX_PEAKS];
    pcnt_t   np_reg;
    pidx_t   eidx_reg;
    pos_t    out_pos_reg;
    sample_t out_level_reg;
    logic    out_none_reg, out_last_reg;

    assign range_s = scaled_t'(max_reg) - scaled_t'(min_reg);

    // sample store
    assign smp_we    = cmd.load && (count_reg < count_t'(BLOCK_SAMPLES));
    assign smp_raddr = cmd.scan ? rd_i_reg[ADDR_W-1:0] : plist_reg[eidx_reg];

    spf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(BLOCK_SAMPLES)) u_sample_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_sample),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    // candidate store: position and raw sample
    assign ext_waddr = len_reg[ADDR_W-1:0];
    assign ext_raddr = ADDR_W'(wk_reg + count_t'(b_reg));

    spf_ram #(.WIDTH(EXT_W), .DEPTH(BLOCK_SAMPLES)) u_ext_ram (
        .clk   (clk),
        .we    (ext_we),
        .waddr (ext_waddr),
        .wdata ({cand_pos, cand_raw}),
        .raddr (ext_raddr),
        .rdata (ext_rdata)
    );

    // derivative sign change detection on the streamed samples
    always_comb
    begin
        scan_issue = cmd.scan && (rd_i_reg < count_reg);
        w_cur      = to_work(smp_rdata, find_min_reg);
        w_prev     = to_work(prev_raw_reg, find_min_reg);
        d_cur      = (w_cur <= w_prev);
        ext_we     = 1'b0;
        cand_pos   = '0;
        cand_raw   = smp_rdata;
        if (cmd.scan && v1_reg)
        begin
            if (j1_reg == '0)
            begin
                ext_we = 1'b1;
            end
            else if (j1_reg > count_t'(1) && d_cur != dprev_reg)
            begin
                ext_we   = 1'b1;
                cand_pos = ADDR_W'(j1_reg - count_t'(1));
                cand_raw = prev_raw_reg;
            end
        end
        if (cmd.scan_end)
        begin
            ext_we   = 1'b1;
            cand_pos = ADDR_W'(count_reg - count_t'(1));
            cand_raw = prev_raw_reg;
        end
        cand_w = to_work(cand_raw, find_min_reg);
    end

    // leading candidates and the two-endpoint case
    always_comb
    begin
        ew0        = to_work(e_raw_reg[0], find_min_reg);
        ew1        = to_work(e_raw_reg[1], find_min_reg);
        ew2        = to_work(e_raw_reg[2], find_min_reg);
        gt0        = ew1 > ew0;
        lt0        = ew1 < ew0;
        gt1        = ew2 > ew1;
        lt1        = ew2 < ew1;
        same       = (gt0 == gt1) && (lt0 == lt1);
        dec_f0_pos = (same && gt0) ? e_pos_reg[1] : e_pos_reg[0];
        dec_f0_val = (same && gt0) ? ew1 : ew0;
        dec_f1_val = same ? ew2 : ew1;
        dec_s      = !(dec_f0_val > dec_f1_val);
        sm_xi      = gt0;
        sm_hit     = times5(sm_xi ? ew1 : ew0) > times5(min_mag_reg) + range_s;
    end

    // one candidate per cycle through the peak/valley walk
    always_comb
    begin
        walk_issue = cmd.walk && (wk_reg < l_reg);
        el_pos     = (k2_reg == '0) ? f0_pos_reg : ext_rdata[EXT_W-1:SAMPLE_BITS];
        el_v       = (k2_reg == '0) ? f0_val_reg
                                    : to_work(ext_rdata[SAMPLE_BITS-1:0], find_min_reg);
        par        = k2_reg[0] ^ s_reg;
        is_end     = (k2_reg == l_reg - count_t'(1));
        tm_eff     = found_reg ? min_mag_reg : temp_mag_reg;
        gap_diff   = $signed({2'b00, el_pos}) - $signed({2'b00, last_pos_reg});
        gap_ok     = (cnt_reg == '0) || (gap_diff > $signed({2'b00, min_gap_reg}));
        peak_ok    = (el_v > tm_eff) && gap_ok
                     && (times5(el_v) > times5(left_min_reg) + range_s);
        valley_hit = times5(temp_mag_reg) > range_s + times5(el_v);
    end

    // last candidate and leftover peak
    always_comb
    begin
        tm_fin       = found_reg ? min_mag_reg : temp_mag_reg;
        fin_hit_last = (last_v_reg > tm_fin)
                       && (times5(last_v_reg) > times5(left_min_reg) + range_s);
        fin_hit_tmp  = tm_fin > min_mag_reg;
        fin_add      = fin_hit_last || fin_hit_tmp;
        fin_pos      = fin_hit_last ? last_p_reg : temp_pos_reg;
        cnt_f        = fin_add ? sat_inc(cnt_reg) : cnt_reg;
        if (cnt_f > pcnt_t'(1))
        begin
            np_f = (cnt_f - pcnt_t'(1) > PEAK_LIMIT) ? PEAK_LIMIT : cnt_f - pcnt_t'(1);
        end
        else
        begin
            np_f = '0;
        end
    end

    always_comb
    begin
        status.scan_done   = v1_reg && (j1_reg == count_reg - count_t'(1));
        status.walk_done   = v2_reg && is_end;
        status.small_block = (len_reg == count_t'(2));
        status.emit_last   = (np_reg == '0) || (pcnt_t'(eidx_reg) == np_reg - pcnt_t'(1));
    end

    assign out_position = out_pos_reg;
    assign out_level    = out_level_reg;
    assign out_none     = out_none_reg;
    assign out_last     = out_last_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg  <= GAP_RESET;
            find_min_reg <= FIND_MIN_RESET;
            count_reg    <= '0;
            max_reg      <= SAMPLE_MIN;
            min_reg      <= SAMPLE_MAX;
            rd_i_reg     <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            wk_reg       <= '0;
            len_reg      <= '0;
            found_reg    <= 1'b0;
            cnt_reg      <= '0;
            np_reg       <= '0;
            eidx_reg     <= '0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_PEAK_GAP: min_gap_reg  <= cfg_data[GAP_W-1:0];
                    REG_FIND_MINIMA:  find_min_reg <= cfg_data[0];
                    default:          ;
                endcase
            end

            // block load
            if (smp_we)
            begin
                count_reg <= count_reg + count_t'(1);
                if (in_sample > max_reg)
                begin
                    max_reg <= in_sample;
                end
                if (in_sample < min_reg)
                begin
                    min_reg <= in_sample;
                end
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                max_reg   <= SAMPLE_MIN;
                min_reg   <= SAMPLE_MAX;
            end

            // scan stream
            if (cmd.scan_init)
            begin
                rd_i_reg <= '0;
                len_reg  <= '0;
            end
            if (scan_issue)
            begin
                rd_i_reg <= rd_i_reg + count_t'(1);
            end
            v1_reg <= scan_issue;
            if (ext_we)
            begin
                len_reg <= len_reg + count_t'(1);
            end

            // walk stream
            if (cmd.decide)
            begin
                wk_reg    <= count_t'(dec_s);
                found_reg <= 1'b0;
                cnt_reg   <= '0;
                eidx_reg  <= '0;
                np_reg    <= sm_hit ? pcnt_t'(1) : '0;
            end
            if (walk_issue)
            begin
                wk_reg <= wk_reg + count_t'(1);
            end
            v2_reg <= walk_issue;
            if (v2_reg)
            begin
                if (!par)
                begin
                    if (!is_end)
                    begin
                        found_reg <= 1'b0;
                    end
                end
                else if (valley_hit)
                begin
                    found_reg <= 1'b1;
                    cnt_reg   <= sat_inc(cnt_reg);
                end
            end

            // closing step and emit
            if (cmd.fin)
            begin
                cnt_reg  <= cnt_f;
                np_reg   <= np_f;
                eidx_reg <= '0;
            end
            if (cmd.emit_next)
            begin
                eidx_reg <= eidx_reg + pidx_t'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prev_raw_reg <= smp_rdata;
            if (j1_reg != '0)
            begin
                dprev_reg <= d_cur;
            end
        end
        j1_reg <= rd_i_reg;

        if (ext_we)
        begin
            if (len_reg == '0 || cand_w < min_mag_reg)
            begin
                min_mag_reg <= cand_w;
            end
            if (len_reg < count_t'(3))
            begin
                e_pos_reg[len_reg[1:0]] <= cand_pos;
                e_raw_reg[len_reg[1:0]] <= cand_raw;
            end
        end

        if (cmd.decide)
        begin
            b_reg        <= same;
            l_reg        <= len_reg - count_t'(same);
            s_reg        <= dec_s;
            f0_pos_reg   <= dec_f0_pos;
            f0_val_reg   <= dec_f0_val;
            temp_mag_reg <= min_mag_reg;
            left_min_reg <= min_mag_reg;
            last_pos_reg <= '0;
            temp_pos_reg <= dec_f0_pos;
            plist_reg[0] <= sm_xi ? e_pos_reg[1] : e_pos_reg[0];
        end

        k2_reg <= wk_reg;
        if (v2_reg)
        begin
            last_v_reg <= el_v;
            last_p_reg <= el_pos;
            if (!par)
            begin
                if (!is_end)
                begin
                    temp_mag_reg <= peak_ok ? el_v : tm_eff;
                    if (peak_ok)
                    begin
                        temp_pos_reg <= el_pos;
                    end
                end
            end
            else if (valley_hit)
            begin
                left_min_reg <= el_v;
                last_pos_reg <= temp_pos_reg;
                if (cnt_reg < PEAK_LIMIT)
                begin
                    plist_reg[cnt_reg[PIDX_W-1:0]] <= temp_pos_reg;
                end
            end
            else if (el_v < left_min_reg)
            begin
                left_min_reg <= el_v;
            end
        end

        if (cmd.fin && fin_add && cnt_reg < PEAK_LIMIT)
        begin
            plist_reg[cnt_reg[PIDX_W-1:0]] <= fin_pos;
        end

        if (cmd.emit_ld)
        begin
            out_none_reg  <= (np_reg == '0);
            out_last_reg  <= status.emit_last;
            out_pos_reg   <= (np_reg == '0) ? '0 : plist_reg[eidx_reg];
            out_level_reg <= (np_reg == '0) ? '0 : smp_rdata;
        end
    end

endmodule

// ===== design/step_peak_finder.sv =====
`timescale 1ns / 1ps

// step peak finder
//
// sample_ch takes one transaction per accelerometer sample; block_end marks
// the last sample of a block. Samples load at one per cycle while the block
// is open; beyond 512 stored samples further ones are dropped.
// After block_end the block is analysed: an extrema scan over the sample
// memory, a step to settle the first candidates, a peak/valley walk over
// the candidate memory (one candidate per cycle) and a closing step, then
// results go out on peak_ch one at a time; when only two candidates are
// found the walk and closing step are skipped. The read port of each memory
// sets the one-per-cycle pace. sample_ch stays not ready from block_end
// until the last result (last_peak set) is taken; a stalled receiver holds
// the result and the block waits. A block with no peak gives one result
// with none_found set. cfg_we writes min_peak_gap (index 0) or find_minima
// (index 1); the user must write them only between blocks, which the block
// itself does not enforce. Reset returns to loading with an empty block,
// min_peak_gap 60 and find_minima 1.

module step_peak_finder (
    input  logic                   clk,
    input  logic                   rst_n,
    spf_sample_if.sink             sample_ch,
    spf_peak_if.source             peak_ch,
    input  logic                   cfg_we,
    input  spf_pkg::cfg_idx_t      cfg_index,
    input  spf_pkg::cfg_data_t     cfg_data
);
    import spf_pkg::*;

    spf_cmd_t    cmd;
    spf_status_t status;

    // sequencing
    spf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sample_ch.valid),
        .in_block_end (sample_ch.block_end),
        .in_ready     (sample_ch.ready),
        .out_ready    (peak_ch.ready),
        .out_valid    (peak_ch.valid),
        .status       (status),
        .cmd          (cmd)
    );

    // storage and arithmetic
    spf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_sample    (sample_ch.sample),
        .out_position (peak_ch.peak_position),
        .out_level    (peak_ch.peak_level),
        .out_none     (peak_ch.none_found),
        .out_last     (peak_ch.last_peak)
    );

endmodule
